/* rtl/xed_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character codes and the entity name lookup for the XML entity decoder.
// Depends on nothing; used by xed_decode and xml_entity_decoder.
package xed_pkg;

  localparam int NAME_MAX = 4;
  localparam int RUN_MAX  = 6;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;

  typedef logic [2:0]                    cnt_t;
  typedef logic [NAME_MAX-1:0][7:0]      name_t;
  typedef logic [RUN_MAX-1:0][7:0]       run_bytes_t;

  typedef struct packed {
    logic  in_entity;
    cnt_t  count;
    name_t names;
  } ent_state_t;

  typedef struct packed {
    run_bytes_t bytes;
    cnt_t       count;
  } run_buf_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } match_t;

  // Matches a held name against the five predefined entities.
  function automatic match_t entity_lookup(name_t names, cnt_t count);
    match_t m;
    m.hit = 1'b1;
    m.ch  = CH_AMP;
    if (count == 3'd3 && names[0] == "a" && names[1] == "m" && names[2] == "p") begin
      m.ch = CH_AMP;
    end else if (count == 3'd2 && names[0] == "l" && names[1] == "t") begin
      m.ch = CH_LT;
    end else if (count == 3'd2 && names[0] == "g" && names[1] == "t") begin
      m.ch = CH_GT;
    end else if (count == 3'd4 && names[0] == "q" && names[1] == "u" &&
                 names[2] == "o" && names[3] == "t") begin
      m.ch = CH_QUOT;
    end else if (count == 3'd4 && names[0] == "a" && names[1] == "p" &&
                 names[2] == "o" && names[3] == "s") begin
      m.ch = CH_APOS;
    end else begin
      m.hit = 1'b0;
    end
    return m;
  endfunction

endpackage

/* rtl/xed_decode.sv */
`timescale 1ns / 1ps
// Combinational decode of one input byte: next entity state and the run of result bytes.
// Depends on xed_pkg.
module xed_decode (
  input  xed_pkg::ent_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                in_end,
  output xed_pkg::ent_state_t st_nxt,
  output xed_pkg::run_buf_t   run
);

  xed_pkg::name_t  name_add;
  xed_pkg::cnt_t   cnt_add;
  xed_pkg::match_t m_cur;
  xed_pkg::match_t m_add;
  xed_pkg::name_t  rel_names;
  xed_pkg::cnt_t   rel_cnt;
  logic            rel_mode;
  logic            tail_en;
  logic [7:0]      tail_byte;
  logic            single_en;
  logic [7:0]      single_byte;

  always_comb begin
    name_add                  = st.names;
    name_add[st.count[1:0]]   = in_byte;
    cnt_add                   = st.count + 3'd1;
  end

  assign m_cur = xed_pkg::entity_lookup(st.names, st.count);
  assign m_add = xed_pkg::entity_lookup(name_add, cnt_add);

  always_comb begin
    st_nxt      = st;
    rel_mode    = 1'b0;
    rel_names   = st.names;
    rel_cnt     = st.count;
    tail_en     = 1'b0;
    tail_byte   = in_byte;
    single_en   = 1'b0;
    single_byte = in_byte;
    priority if (!st.in_entity) begin
      if (in_byte == xed_pkg::CH_AMP && !in_end) begin
        st_nxt.in_entity = 1'b1;
        st_nxt.count     = 3'd0;
      end else begin
        single_en = 1'b1;
      end
    end else if (in_byte == xed_pkg::CH_SEMI) begin
      if (m_cur.hit) begin
        single_en   = 1'b1;
        single_byte = m_cur.ch;
      end else begin
        rel_mode = 1'b1;
        tail_en  = 1'b1;
      end
      st_nxt.in_entity = 1'b0;
      st_nxt.count     = 3'd0;
    end else if (in_byte == xed_pkg::CH_AMP) begin
      // An ampersand flushes the open entity and, unless the string ends, opens a new one.
      rel_mode     = 1'b1;
      tail_en      = in_end;
      st_nxt.count = 3'd0;
    end else if (st.count < 3'(xed_pkg::NAME_MAX)) begin
      st_nxt.names = name_add;
      st_nxt.count = cnt_add;
      if (in_end) begin
        if (m_add.hit) begin
          single_en   = 1'b1;
          single_byte = m_add.ch;
        end else begin
          rel_mode  = 1'b1;
          rel_names = name_add;
          rel_cnt   = cnt_add;
        end
      end
    end else begin
      // Name too long: flush everything together with this byte.
      rel_mode         = 1'b1;
      tail_en          = 1'b1;
      st_nxt.in_entity = 1'b0;
      st_nxt.count     = 3'd0;
    end
    if (in_end) begin
      st_nxt.in_entity = 1'b0;
      st_nxt.count     = 3'd0;
    end
  end

  always_comb begin
    run.bytes = '0;
    run.count = 3'd0;
    if (single_en) begin
      run.bytes[0] = single_byte;
      run.count    = 3'd1;
    end else if (rel_mode) begin
      run.bytes[0] = xed_pkg::CH_AMP;
      for (int i = 1; i < xed_pkg::RUN_MAX; i++) begin
        if (i <= xed_pkg::NAME_MAX && 3'(i - 1) < rel_cnt) begin
          run.bytes[i] = rel_names[2'(i - 1)];
        end else begin
          run.bytes[i] = tail_byte;
        end
      end
      run.count = rel_cnt + 3'd1 + {2'b00, tail_en};
    end
  end

endmodule

/* rtl/xml_entity_decoder.sv */
`timescale 1ns / 1ps
// Top level of the streaming XML predefined entity decoder.
// Depends on xed_pkg and xed_decode.
//
// Usage. The input channel (in_valid, in_stall, in_byte, in_end) carries one byte of an
// encoded string per transfer; in_end marks the last byte of a string. The result
// channel (out_valid, out_stall, out_byte, out_run_last, out_string_end) carries the
// decoded bytes one per transfer. The five predefined entities are replaced by their
// characters; anything that does not decode is passed on unchanged. out_run_last marks
// the last byte caused by one input byte, and out_string_end the final byte of a string.
// An input byte may cause no result at all (an opening ampersand or a held name byte).
// A transferred input byte is registered, then decoded once the run buffer can take
// a new run, and its results are written into the run buffer and offered from there.
// Throughput: one input byte per cycle while each byte yields at most one result and the
// receiver does not stall. A byte that releases a held entity yields up to six results,
// one per cycle while out_stall is low; a run holds the next input byte in the input
// register until the run's final byte leaves.
// Reset (rst_n low, synchronous) empties the input register and the run buffer and
// leaves the decoder outside any entity. When the receiver raises out_stall the current
// result holds steady, and once the input register is also full in_stall rises.
module xml_entity_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);

  // Input register.
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  // Entity state and the run buffer that holds the results of one input byte.
  xed_pkg::ent_state_t st_r;
  xed_pkg::ent_state_t st_nxt;
  xed_pkg::run_buf_t   run_dec;
  xed_pkg::run_bytes_t run_bytes_r;
  xed_pkg::cnt_t       run_cnt_r;
  logic                run_end_r;

  logic in_take;
  logic advance;
  logic pop;

  // The run buffer can take a new run when it is empty or its final byte leaves now.
  assign pop      = out_valid && !out_stall;
  assign advance  = (run_cnt_r == 3'd0) || (run_cnt_r == 3'd1 && !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  xed_decode u_decode (
    .st      (st_r),
    .in_byte (in_byte_r),
    .in_end  (in_end_r),
    .st_nxt  (st_nxt),
    .run     (run_dec)
  );

  // The held name bytes carry no reset; they are only read below the held count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      st_r.in_entity <= 1'b0;
      st_r.count   <= 3'd0;
      run_cnt_r    <= 3'd0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (in_v_r && advance) begin
        st_r.in_entity <= st_nxt.in_entity;
        st_r.count     <= st_nxt.count;
        st_r.names     <= st_nxt.names;
        run_cnt_r      <= run_dec.count;
      end else if (pop) begin
        run_cnt_r <= run_cnt_r - 3'd1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte;
      in_end_r  <= in_end;
    end
    if (in_v_r && advance) begin
      run_bytes_r <= run_dec.bytes;
      run_end_r   <= in_end_r;
    end else if (pop) begin
      run_bytes_r <= run_bytes_r >> 8;
    end
  end

  assign out_valid      = (run_cnt_r != 3'd0);
  assign out_byte       = run_bytes_r[0];
  assign out_run_last   = (run_cnt_r == 3'd1);
  assign out_string_end = (run_cnt_r == 3'd1) && run_end_r;

endmodule

/* verif/xed_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the XML entity decoder: predicts decoded bytes from input transfers
// and compares them with result transfers. Depends on xed_pkg.
module xed_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  input  logic       out_string_end,
  output int         n_fail,
  output int         n_pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } dec_byte_t;

  dec_byte_t  decoded_q [$];
  dec_byte_t  run_buf [xed_pkg::RUN_MAX];
  int         run_n;
  logic       in_ent;
  logic [7:0] held [xed_pkg::NAME_MAX];
  int         held_cnt;
  int         errs = 0;

  initial begin
    n_fail    = 0;
    n_pending = 0;
  end

  function automatic void run_push(logic [7:0] b);
    if (run_n < xed_pkg::RUN_MAX) begin
      run_buf[run_n] = '{data: b, run_last: 1'b0, string_end: 1'b0};
      run_n++;
    end
  endfunction

  function automatic void release_name();
    run_push(xed_pkg::CH_AMP);
    for (int i = 0; i < held_cnt; i++) run_push(held[i]);
  endfunction

  // Hit flag above the decoded character.
  function automatic logic [8:0] name_match();
    case (held_cnt)
      2: begin
        if ({held[0], held[1]} == "lt") return {1'b1, xed_pkg::CH_LT};
        if ({held[0], held[1]} == "gt") return {1'b1, xed_pkg::CH_GT};
      end
      3: begin
        if ({held[0], held[1], held[2]} == "amp") return {1'b1, xed_pkg::CH_AMP};
      end
      4: begin
        if ({held[0], held[1], held[2], held[3]} == "quot")
          return {1'b1, xed_pkg::CH_QUOT};
        if ({held[0], held[1], held[2], held[3]} == "apos")
          return {1'b1, xed_pkg::CH_APOS};
      end
      default: ;
    endcase
    return 9'd0;
  endfunction

  function automatic void decode_byte(logic [7:0] c, logic last_of_string);
    logic [8:0] m;
    run_n = 0;
    if (!in_ent) begin
      if (c == xed_pkg::CH_AMP && !last_of_string) begin
        in_ent   = 1'b1;
        held_cnt = 0;
      end else begin
        run_push(c);
      end
    end else if (c == xed_pkg::CH_SEMI) begin
      m = name_match();
      if (m[8]) begin
        run_push(m[7:0]);
      end else begin
        release_name();
        run_push(xed_pkg::CH_SEMI);
      end
      in_ent   = 1'b0;
      held_cnt = 0;
    end else if (c == xed_pkg::CH_AMP) begin
      release_name();
      held_cnt = 0;
      if (last_of_string) run_push(xed_pkg::CH_AMP);
    end else if (held_cnt < xed_pkg::NAME_MAX) begin
      held[held_cnt] = c;
      held_cnt++;
      if (last_of_string) begin
        m = name_match();
        if (m[8]) run_push(m[7:0]);
        else release_name();
      end
    end else begin
      release_name();
      run_push(c);
      in_ent   = 1'b0;
      held_cnt = 0;
    end
    if (last_of_string) begin
      in_ent   = 1'b0;
      held_cnt = 0;
    end
    if (run_n > 0) begin
      run_buf[run_n-1].run_last   = 1'b1;
      run_buf[run_n-1].string_end = last_of_string;
    end
    for (int i = 0; i < run_n; i++) decoded_q.push_back(run_buf[i]);
  endfunction

  always @(posedge clk) begin : watch
    dec_byte_t want;
    if (!rst_n) begin
      in_ent   = 1'b0;
      held_cnt = 0;
      decoded_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_byte, in_end);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %h run_last %b end %b",
                   $time, out_byte, out_run_last, out_string_end);
          errs++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %h, got %h", $time, want.data, out_byte);
            errs++;
          end
          if (out_run_last !== want.run_last) begin
            $display("%0t: out_run_last expected %b, got %b",
                     $time, want.run_last, out_run_last);
            errs++;
          end
          if (out_string_end !== want.string_end) begin
            $display("%0t: out_string_end expected %b, got %b",
                     $time, want.string_end, out_string_end);
            errs++;
          end
        end
      end
    end
    n_pending <= decoded_q.size();
    n_fail    <= errs;
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Top of the XML entity decoder testbench: clock, reset, stimulus and verdict.
// Depends on xed_pkg, xml_entity_decoder and xed_checker.
module tb;

  // Cycles without any transfer before the run is declared hung. The longest quiet
  // stretch in a correct run is the deliberate receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 80;
  localparam int ITEMS_PER_PHASE = 145;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       in_end    = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_end;

  int n_fail;
  int n_pending;
  int n_sent   = 0;
  int tx_pct   = 38;
  int rx_pct   = 51;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  string ent_names [5] = '{"amp", "lt", "gt", "quot", "apos"};
  string name_chars    = "amplgtquos";

  xml_entity_decoder u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_end        (in_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_string_end(out_string_end)
  );

  xed_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_end        (in_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_string_end(out_string_end),
    .n_fail        (n_fail),
    .n_pending     (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver. Each cycle it stalls with the probability of the current phase. When the
  // stimulus asks for a hold-off it keeps out_stall high for a long, fixed stretch so
  // that the run buffer and the input register fill and the block pushes back on the
  // sender.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  // Watchdog. Any transfer on either channel restarts the count; a run that goes quiet
  // for too long is treated as a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one byte and returns at the edge where its transfer takes place. Idle
  // cycles are inserted before the byte, so valid is only ever lowered at the edge of
  // a transfer and raised again at a later edge. The payload holds while stalled.
  task automatic send_byte(logic [7:0] b, logic last_of_string);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_end   <= last_of_string;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_text(string s, bit ends_string);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], ends_string && (i == s.len() - 1));
  endtask

  // Builds one string out of random pieces and sends it, marking its last byte. Four in
  // ten pieces are well-formed entities, so that matches are exercised often; the rest are
  // plain bytes, empty, truncated, over-long and unterminated names, and stray
  // ampersands. A string that ends inside a piece tests the end-of-string matching.
  task automatic send_random_string();
    logic [7:0] txt [$];
    int         n_pieces;
    int         kind;
    int         len;
    string      nm;
    n_pieces = $urandom_range(1, 6);
    for (int p = 0; p < n_pieces; p++) begin
      kind = $urandom_range(0, 9);
      nm   = ent_names[$urandom_range(0, 4)];
      case (kind)
        0, 1, 2, 3: begin
          txt.push_back(xed_pkg::CH_AMP);
          for (int i = 0; i < nm.len(); i++) txt.push_back(nm[i]);
          txt.push_back(xed_pkg::CH_SEMI);
        end
        4, 5: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) txt.push_back(8'($urandom_range(0, 255)));
        end
        6: begin
          // A proper prefix of a real name, with or without the closing semicolon.
          txt.push_back(xed_pkg::CH_AMP);
          len = $urandom_range(0, nm.len() - 1);
          for (int i = 0; i < len; i++) txt.push_back(nm[i]);
          if ($urandom_range(1)) txt.push_back(xed_pkg::CH_SEMI);
        end
        7: begin
          // Names of five or six letters overflow the name store.
          txt.push_back(xed_pkg::CH_AMP);
          len = $urandom_range(5, 6);
          for (int i = 0; i < len; i++)
            txt.push_back(name_chars[$urandom_range(0, name_chars.len() - 1)]);
          if ($urandom_range(1)) txt.push_back(xed_pkg::CH_SEMI);
        end
        8: begin
          txt.push_back(xed_pkg::CH_AMP);
        end
        default: begin
          // A real name left open: matched only if the string ends right here.
          txt.push_back(xed_pkg::CH_AMP);
          for (int i = 0; i < nm.len(); i++) txt.push_back(nm[i]);
        end
      endcase
    end
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  initial begin
    int phase_start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles often, receiver stalls more often still.
    tx_pct = 38;
    rx_pct = 51;

    // Directed strings: a match closed by a semicolon, an ampersand inside an entity
    // followed by a match, an empty name, an over-long name with a trailing semicolon
    // that must pass as a plain byte, a lone ampersand at the end of a string, and a
    // full-length name matched at the end of a string.
    send_text("&amp;", 1'b0);
    send_text("&&gt;", 1'b0);
    send_text("&;", 1'b0);
    send_text("&quots;", 1'b0);
    send_text("&", 1'b1);
    send_text("&apos", 1'b1);

    phase_start = n_sent;
    while (n_sent - phase_start < ITEMS_PER_PHASE) send_random_string();

    // Phase two: the idling rates are swapped.
    tx_pct = 51;
    rx_pct = 38;
    phase_start = n_sent;
    while (n_sent - phase_start < ITEMS_PER_PHASE) send_random_string();

    // Phase three: no idling at all, opened by a long receiver hold-off while the
    // sender keeps offering bytes back to back.
    tx_pct   = 0;
    rx_pct   = 0;
    hold_req = 1'b1;
    phase_start = n_sent;
    while (n_sent - phase_start < ITEMS_PER_PHASE) send_random_string();
    in_valid <= 1'b0;

    // Let the checker see the last transfer, wait for every predicted byte, then allow
    // for the pipeline and the run buffer so that any stray result is still caught.
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (n_fail == 0 && n_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* xml_entity_decoder.f */
rtl/xed_pkg.sv
rtl/xed_decode.sv
rtl/xml_entity_decoder.sv
verif/xed_checker.sv
verif/tb.sv
